FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, sampled on i_clk, off while in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cbfs_pkg.sv
// ---------------------------------------------------------------------------
// cbfs_pkg
// shared sizes, codes and request/result types of the current budget sharer
// ---------------------------------------------------------------------------
package cbfs_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int AMT_W     = 16;
    localparam int IDXO_W    = 4;
    localparam int DIV_STEPS = AMT_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int Q_DEPTH   = 2;
    localparam int QPTR_W    = $clog2(Q_DEPTH);
    localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic CLS_ALWAYS = 1'b0;
    localparam logic CLS_SHARE  = 1'b1;

    typedef struct packed {
        logic [AMT_W-1:0] request_amount;
        logic             priority_class;
    } t_req;

    typedef struct packed {
        logic [IDXO_W-1:0] entry_index;
        logic [AMT_W-1:0]  allowance;
        logic              rejected;
        logic              last;
    } t_res;

    // one queued run: number of entries to process and the reject mark
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             rejected;
    } t_job;

    // table write from the front end
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [AMT_W-1:0] amt;
        logic             cls;
    } t_tbl_wr;

endpackage

FILE: src/cbfs_front.sv
// ---------------------------------------------------------------------------
// cbfs_front
// takes requests, appends them to the table or marks them rejected when full,
// and queues one run per request
// ---------------------------------------------------------------------------
module cbfs_front import cbfs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_req    i_req,
    input  logic    i_q_full,
    output logic    o_busy,
    output logic    o_push,
    output t_job    o_job,
    output t_tbl_wr o_wr
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_full;

    assign w_accept = i_start & ~i_q_full;
    assign w_full   = (r_count == CNT_W'(ENTRIES));
    assign o_busy   = i_q_full;

    always_comb begin
        o_wr.we  = w_accept & ~w_full;
        o_wr.addr = r_count[IDX_W-1:0];
        o_wr.amt = i_req.request_amount;
        o_wr.cls = i_req.priority_class;

        o_push         = w_accept;
        o_job.rejected = w_full;
        o_job.n        = w_full ? r_count : r_count + CNT_W'(1);

        n_count = (w_accept && !w_full) ? r_count + CNT_W'(1) : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

FILE: src/cbfs_queue.sv
// ---------------------------------------------------------------------------
// cbfs_queue
// short run queue between front end and allocation engine
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbfs_queue import cbfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers wrap naturally, depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    `ASSERT_IMPLY(a_no_overflow, i_push, !o_full, "run queue written while full")
    `ASSERT_IMPLY(a_no_underflow, i_pop, !o_empty, "run queue read while empty")

endmodule

FILE: src/cbfs_div.sv
// ---------------------------------------------------------------------------
// cbfs_div
// unsigned restoring divider, remaining budget by open count, two bits a cycle
// ---------------------------------------------------------------------------
module cbfs_div import cbfs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AMT_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [AMT_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [AMT_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [AMT_W-1:0]  n_num;
    logic [CNT_W-1:0]  n_rem;
    logic [CNT_W:0]    w_trial;

    // numerator shifts out at the top while quotient bits enter at the bottom
    always_comb begin
        n_num   = r_num;
        n_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < 2; k++) begin
            w_trial = {n_rem, n_num[AMT_W-1]};
            n_num   = {n_num[AMT_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                w_trial  = w_trial - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
            n_rem = w_trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_STEPS - 1);
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

FILE: src/cbfs_back.sv
// ---------------------------------------------------------------------------
// cbfs_back
// allocation engine: grants fixed requests, water-fills the shared ones over
// repeated passes, then reports every allowance in table order
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbfs_back import cbfs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [AMT_W-1:0] i_cfg_wdata,
    input  t_tbl_wr          i_wr,
    input  logic             i_q_empty,
    input  t_job             i_q_head,
    output logic             o_pop,
    output logic             o_res_stb,
    output t_res             o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT_RD,
        S_INIT_EX,
        S_PASS_RD,
        S_PASS_EX,
        S_DIV,
        S_OUT_RD,
        S_OUT_EX
    } t_state;

    // request and grant tables
    logic [AMT_W-1:0] r_mem_amt   [ENTRIES];
    logic             r_mem_cls   [ENTRIES];
    logic [AMT_W-1:0] r_mem_grant [ENTRIES];
    logic [AMT_W-1:0] r_rd_amt;
    logic             r_rd_cls;
    logic [AMT_W-1:0] r_rd_grant;

    t_state           r_state,      n_state;
    t_job             r_job,        n_job;
    logic [IDX_W-1:0] r_idx,        n_idx;
    logic [AMT_W-1:0] r_rem,        n_rem;
    logic [CNT_W-1:0] r_open,       n_open;
    logic [AMT_W-1:0] r_share,      n_share;
    logic             r_share_ok,   n_share_ok;
    logic             r_closed_any, n_closed_any;
    logic [ENTRIES-1:0] r_closed,   n_closed;
    logic             r_out_vld,    n_out_vld;
    t_res             r_out,        n_out;
    logic [AMT_W-1:0] r_budget;

    logic             w_last;
    logic             w_step;
    logic             w_g_we;
    logic [AMT_W-1:0] w_g_data;
    logic             w_div_start;
    logic             w_div_done;
    logic [AMT_W-1:0] w_div_quot;

    cbfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rem),
        .i_divisor  (r_open),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem_amt[i_wr.addr] <= i_wr.amt;
            r_mem_cls[i_wr.addr] <= i_wr.cls;
        end
        if (w_g_we) begin
            r_mem_grant[r_idx] <= w_g_data;
        end
        r_rd_amt   <= r_mem_amt[r_idx];
        r_rd_cls   <= r_mem_cls[r_idx];
        r_rd_grant <= r_mem_grant[r_idx];
    end

    assign w_last = (r_idx == IDX_W'(r_job.n - CNT_W'(1)));

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_idx        = r_idx;
        n_rem        = r_rem;
        n_open       = r_open;
        n_share      = r_share;
        n_share_ok   = r_share_ok;
        n_closed_any = r_closed_any;
        n_closed     = r_closed;
        n_out_vld    = 1'b0;
        n_out        = r_out;
        o_pop        = 1'b0;
        w_div_start  = 1'b0;
        w_step       = 1'b0;
        w_g_we       = 1'b0;
        w_g_data     = r_rd_amt;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_q_head;
                    n_idx   = '0;
                    n_rem   = r_budget;
                    n_open  = '0;
                    n_state = S_INIT_RD;
                end
            end
            S_INIT_RD: begin
                n_state = S_INIT_EX;
            end
            S_INIT_EX: begin
                w_g_we = 1'b1;
                if (r_rd_cls == CLS_ALWAYS) begin
                    w_g_data        = r_rd_amt;
                    n_closed[r_idx] = 1'b1;
                    // remainder floors at zero when fixed grants overdraw
                    n_rem = (r_rd_amt >= r_rem) ? '0 : r_rem - r_rd_amt;
                end else begin
                    w_g_data        = '0;
                    n_closed[r_idx] = 1'b0;
                    n_open          = r_open + CNT_W'(1);
                end
                if (w_last) begin
                    n_idx        = '0;
                    n_share_ok   = 1'b0;
                    n_closed_any = 1'b0;
                    n_state      = (n_open == '0) ? S_OUT_RD : S_PASS_RD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_INIT_RD;
                end
            end
            S_PASS_RD: begin
                n_state = S_PASS_EX;
            end
            S_PASS_EX: begin
                if (r_rd_cls == CLS_ALWAYS || r_closed[r_idx]) begin
                    w_step = 1'b1;
                end else if (!r_share_ok) begin
                    // share is computed before the first open entry and recomputed only after an entry closes
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    w_step = 1'b1;
                    w_g_we = 1'b1;
                    if (r_share >= r_rd_amt) begin
                        w_g_data        = r_rd_amt;
                        n_closed[r_idx] = 1'b1;
                        n_open          = r_open - CNT_W'(1);
                        n_rem           = r_rem - r_rd_amt;
                        n_share_ok      = 1'b0;
                        n_closed_any    = 1'b1;
                    end else begin
                        w_g_data = r_share;
                    end
                end
                if (w_step) begin
                    if (w_last) begin
                        n_idx = '0;
                        // a pass that closes nothing is a fixed point
                        if (n_closed_any && n_open != '0) begin
                            n_closed_any = 1'b0;
                            n_state      = S_PASS_RD;
                        end else begin
                            n_state = S_OUT_RD;
                        end
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_PASS_RD;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_share    = w_div_quot;
                    n_share_ok = 1'b1;
                    n_state    = S_PASS_EX;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_EX;
            end
            S_OUT_EX: begin
                n_out_vld         = 1'b1;
                n_out.entry_index = IDXO_W'(r_idx);
                n_out.allowance   = r_rd_grant;
                n_out.rejected    = r_job.rejected;
                n_out.last        = w_last;
                if (w_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_open       <= '0;
            r_share_ok   <= 1'b0;
            r_closed_any <= 1'b0;
            r_closed     <= '0;
            r_out_vld    <= 1'b0;
            r_budget     <= '0;
            r_job        <= '0;
        end else begin
            r_state      <= n_state;
            r_job        <= n_job;
            r_idx        <= n_idx;
            r_open       <= n_open;
            r_share_ok   <= n_share_ok;
            r_closed_any <= n_closed_any;
            r_closed     <= n_closed;
            r_out_vld    <= n_out_vld;
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
        end
        r_rem   <= n_rem;
        r_share <= n_share;
        r_out   <= n_out;
    end

    assign o_res_stb = r_out_vld;
    assign o_res     = r_out;

    `ASSERT_IMPLY(a_open_bound, r_state != S_IDLE, r_open <= r_job.n, "open count above entries")
    `ASSERT_IMPLY(a_last_idle, r_out_vld && r_out.last, r_state == S_IDLE, "run not ended on last")
    `ASSERT_NEXT(a_stb_gap, r_out_vld, !r_out_vld, "results issued back to back")

endmodule

FILE: src/current_budget_fair_share_top.sv
// ---------------------------------------------------------------------------
// current_budget_fair_share_top
// max-min fair sharing of a current budget over a table of requests
// ---------------------------------------------------------------------------
// a run makes an initial pass over its n entries, then sharing passes until a pass
//   closes no entry, dividing for a new share before the first open entry and after each close
// results are issued in table order, with a gap between strobes
// throughput is set by the single pass engine; a two-deep run queue lets
//   busy stay low while a run is in progress
// synchronous reset clears entry count, budget, closed flags and the queue
module current_budget_fair_share_top import cbfs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_req             i_req,
    output logic             busy,
    input  logic             i_cfg_we,
    input  logic [AMT_W-1:0] i_cfg_wdata,
    output logic             o_res_stb,
    output t_res             o_res
);

    logic    w_q_full;
    logic    w_q_empty;
    logic    w_push;
    logic    w_pop;
    t_job    w_job;
    t_job    w_head;
    t_tbl_wr w_wr;

    cbfs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_q_full (w_q_full),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_job    (w_job),
        .o_wr     (w_wr)
    );

    cbfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    cbfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_wr        (w_wr),
        .i_q_empty   (w_q_empty),
        .i_q_head    (w_head),
        .o_pop       (w_pop),
        .o_res_stb   (o_res_stb),
        .o_res       (o_res)
    );

endmodule
